[hdl/kpg_pkg.sv]
// Package with shared types and constants of the keyed permutation generator.
`timescale 1ns / 1ps
package kpg_pkg;
  localparam int unsigned DEFAULT_MAX_LENGTH = 4096;
  localparam int unsigned TW_N = 624;
  localparam int unsigned TW_M = 397;
  localparam logic [31:0] TW_MATRIX = 32'h9908b0df;
  localparam logic [31:0] TW_MASK_B = 32'h9d2c5680;
  localparam logic [31:0] TW_MASK_C = 32'hefc60000;
  localparam logic [31:0] TW_INIT_MUL = 32'd1812433253;
  localparam logic [31:0] SEED_RESET = 32'd5489;
  localparam logic [12:0] LEN_RESET = 13'd1;
  localparam logic [0:0] CFG_SEED_KEY = 1'b0;
  localparam logic [0:0] CFG_PERM_LENGTH = 1'b1;
  localparam logic OP_GENERATE = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEED, ST_SEED_MUL, ST_FILL, ST_REF_RD, ST_REF_WR,
    ST_DRAW_RD, ST_DRAW_TMP, ST_MOD, ST_SWAP_RD, ST_SWAP_WR1, ST_SWAP_WR2,
    ST_READ, ST_OUT
  } kpg_state_t;

  function automatic logic [31:0] tw_temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & TW_MASK_B);
    y = y ^ ((y << 15) & TW_MASK_C);
    y = y ^ (y >> 18);
    return y;
  endfunction
endpackage

[hdl/keyed_permutation_generator.sv]
// Top level of the keyed permutation generator.
//   channel | direction | ports
//   in      | input     | in_valid, in_ready, in_op, in_read_index
//   out     | output    | out_valid, out_ready, out_perm_value, out_error_flag
//   cfg     | input     | cfg_valid, cfg_ready, cfg_index, cfg_data
// A valid read passes through ST_READ and ST_OUT into the result register; a rejected
// read is written to the result register straight from idle. A generate seeds the
// twister, fills the table and runs shuffle steps (a restoring remainder unit dominates
// each step), with one twister refill for every 624 draws.
// Twister words and the table sit in single-port RAMs; one access per cycle
// sets the pace. No item is taken while a result waits in the output register.
`timescale 1ns / 1ps
module keyed_permutation_generator #(
  parameter int unsigned MAX_LENGTH = kpg_pkg::DEFAULT_MAX_LENGTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [11:0]                   in_read_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [11:0]                   out_perm_value,
  output logic                          out_error_flag,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [31:0]                   cfg_data
);
  import kpg_pkg::*;

  localparam int unsigned AW = $clog2(MAX_LENGTH);
  localparam int unsigned LW = $clog2(MAX_LENGTH + 1);
  localparam int unsigned TW = $clog2(TW_N);

  kpg_state_t state_r, state_nxt;
  logic [31:0] seed_r;
  logic [12:0] len_cfg_r;
  logic        ready_r;
  logic [LW-1:0] gen_len_r;
  logic [TW:0] ptr_r, ptr_nxt;
  logic [TW-1:0] twi_r, twi_nxt;
  logic [31:0] prev_r, prev_nxt, wa_r, wa_nxt;
  logic [LW-1:0] m_r, m_nxt;
  logic [AW-1:0] fidx_r, fidx_nxt;
  logic [31:0] rem_r, rem_nxt, quo_r, quo_nxt;
  logic [5:0] bit_r, bit_nxt;
  logic [11:0] tval_r, tval_nxt;
  logic [11:0] oval_r, oval_nxt;
  logic oerr_r, oerr_nxt, ovalid_r, ovalid_nxt;
  logic [AW-1:0] ridx_r, ridx_nxt;

  logic tw_we;
  logic [TW-1:0] tw_addr;
  logic [31:0] tw_wdata, tw_rdata;
  logic pt_we;
  logic [AW-1:0] pt_addr;
  logic [11:0] pt_wdata, pt_rdata;

  kpg_ram #(.WIDTH(32), .DEPTH(TW_N)) u_tw_ram (
    .clk(clk), .we(tw_we), .addr(tw_addr), .wdata(tw_wdata), .rdata(tw_rdata));
  kpg_ram #(.WIDTH(12), .DEPTH(MAX_LENGTH)) u_pt_ram (
    .clk(clk), .we(pt_we), .addr(pt_addr), .wdata(pt_wdata), .rdata(pt_rdata));

  logic [LW-1:0] len_sat;
  assign len_sat = ({19'd0, len_cfg_r} > 32'(MAX_LENGTH)) ? LW'(MAX_LENGTH)
                                                          : LW'(len_cfg_r);

  assign in_ready  = (state_r == ST_IDLE) && !ovalid_r;
  assign cfg_ready = 1'b1;
  assign out_valid = ovalid_r;
  assign out_perm_value = oval_r;
  assign out_error_flag = oerr_r;

  logic [TW-1:0] twm_addr;
  assign twm_addr = ({1'b0, twi_r} + (TW+1)'(TW_M) >= (TW+1)'(TW_N))
                    ? TW'({1'b0, twi_r} + (TW+1)'(TW_M) - (TW+1)'(TW_N))
                    : TW'({1'b0, twi_r} + (TW+1)'(TW_M));

  logic [31:0] shl;
  logic [32:0] trial;
  always_comb begin
    shl   = {rem_r[30:0], quo_r[31]};
    trial = {1'b0, shl} - {{(33-LW){1'b0}}, m_r};
  end

  always_comb begin
    state_nxt = state_r;
    ptr_nxt = ptr_r; twi_nxt = twi_r; prev_nxt = prev_r; wa_nxt = wa_r;
    m_nxt = m_r; fidx_nxt = fidx_r; rem_nxt = rem_r; quo_nxt = quo_r;
    bit_nxt = bit_r; tval_nxt = tval_r; oval_nxt = oval_r; oerr_nxt = oerr_r;
    ovalid_nxt = ovalid_r && !out_ready; ridx_nxt = ridx_r;
    tw_we = 1'b0; tw_addr = twi_r; tw_wdata = '0;
    pt_we = 1'b0; pt_addr = fidx_r; pt_wdata = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_op == OP_GENERATE) begin
            tw_we = 1'b1; tw_addr = '0; tw_wdata = seed_r;
            prev_nxt = seed_r; twi_nxt = TW'(1);
            state_nxt = ST_SEED_MUL;
          end else if (!ready_r || {1'b0, in_read_index} >= 13'(gen_len_r)) begin
            oval_nxt = '0; oerr_nxt = 1'b1; ovalid_nxt = 1'b1;
          end else begin
            ridx_nxt = AW'(in_read_index);
            state_nxt = ST_READ;
          end
        end
      end
      ST_SEED_MUL: begin
        // Product is registered before the add and write.
        wa_nxt = TW_INIT_MUL * (prev_r ^ (prev_r >> 30));
        state_nxt = ST_SEED;
      end
      ST_SEED: begin
        tw_we = 1'b1; tw_wdata = wa_r + 32'(twi_r);
        prev_nxt = wa_r + 32'(twi_r);
        if (twi_r == TW'(TW_N - 1)) begin
          ptr_nxt = (TW+1)'(TW_N); fidx_nxt = '0; state_nxt = ST_FILL;
        end else begin
          twi_nxt = twi_r + TW'(1); state_nxt = ST_SEED_MUL;
        end
      end
      ST_FILL: begin
        if (len_sat == '0) begin
          state_nxt = ST_OUT; m_nxt = '0;
        end else begin
          pt_we = 1'b1; pt_wdata = 12'(fidx_r);
          if (LW'(fidx_r) == len_sat - LW'(1)) begin
            m_nxt = len_sat; state_nxt = ST_DRAW_RD;
          end else begin
            fidx_nxt = fidx_r + AW'(1);
          end
        end
      end
      ST_DRAW_RD: begin
        if (ptr_r >= (TW+1)'(TW_N)) begin
          twi_nxt = '0; tw_addr = '0; state_nxt = ST_REF_RD; bit_nxt = '0;
        end else begin
          tw_addr = TW'(ptr_r); state_nxt = ST_DRAW_TMP;
        end
      end
      ST_REF_RD: begin
        // Phases: address word i, take it and address i+1, form the mixed word
        // and address i+M, then hold i+M so its data is there for the write.
        unique case (bit_r[1:0])
          2'd0: begin
            bit_nxt = 6'd1;
          end
          2'd1: begin
            wa_nxt = tw_rdata;
            tw_addr = (twi_r == TW'(TW_N - 1)) ? '0 : twi_r + TW'(1);
            bit_nxt = 6'd2;
          end
          2'd2: begin
            prev_nxt = {wa_r[31], tw_rdata[30:0]};
            tw_addr = twm_addr;
            bit_nxt = 6'd3;
          end
          default: begin
            tw_addr = twm_addr;
            state_nxt = ST_REF_WR;
          end
        endcase
      end
      ST_REF_WR: begin
        tw_we = 1'b1;
        tw_wdata = tw_rdata ^ (prev_r >> 1) ^ (prev_r[0] ? TW_MATRIX : 32'd0);
        bit_nxt = '0;
        if (twi_r == TW'(TW_N - 1)) begin
          ptr_nxt = '0; state_nxt = ST_DRAW_RD;
        end else begin
          twi_nxt = twi_r + TW'(1); tw_addr = twi_r; state_nxt = ST_REF_RD;
        end
      end
      ST_DRAW_TMP: begin
        ptr_nxt = ptr_r + (TW+1)'(1);
        quo_nxt = tw_temper(tw_rdata); rem_nxt = '0; bit_nxt = 6'd32;
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        if (trial[32]) begin
          rem_nxt = shl;
        end else begin
          rem_nxt = trial[31:0];
        end
        quo_nxt = {quo_r[30:0], 1'b0};
        bit_nxt = bit_r - 6'd1;
        if (bit_r == 6'd1) begin
          state_nxt = ST_SWAP_RD; bit_nxt = '0;
        end
      end
      ST_SWAP_RD: begin
        // Phase 0 reads entry m-1, phase 1 keeps it and reads entry r.
        if (bit_r == '0) begin
          pt_addr = AW'(m_r - LW'(1)); bit_nxt = 6'd1;
        end else if (bit_r == 6'd1) begin
          tval_nxt = pt_rdata; pt_addr = AW'(rem_r); bit_nxt = 6'd2;
        end else begin
          pt_addr = AW'(rem_r); state_nxt = ST_SWAP_WR1;
        end
      end
      ST_SWAP_WR1: begin
        pt_we = 1'b1; pt_addr = AW'(m_r - LW'(1)); pt_wdata = pt_rdata;
        state_nxt = ST_SWAP_WR2;
      end
      ST_SWAP_WR2: begin
        pt_we = 1'b1; pt_addr = AW'(rem_r); pt_wdata = tval_r;
        m_nxt = m_r - LW'(1);
        state_nxt = (m_r == LW'(1)) ? ST_OUT : ST_DRAW_RD;
      end
      ST_READ: begin
        pt_addr = ridx_r; state_nxt = ST_OUT; m_nxt = m_r;
      end
      ST_OUT: begin
        pt_addr = ridx_r;
        oval_nxt = '0; oerr_nxt = 1'b0; ovalid_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Distinguish read completion from generate completion at ST_OUT.
  logic is_read_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; seed_r <= SEED_RESET; len_cfg_r <= LEN_RESET;
      ready_r <= 1'b0; gen_len_r <= '0; ptr_r <= '0; ovalid_r <= 1'b0;
      is_read_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ptr_r <= ptr_nxt; ovalid_r <= ovalid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SEED_KEY) seed_r <= cfg_data;
        else len_cfg_r <= cfg_data[12:0];
      end
      if (state_r == ST_IDLE && in_valid && in_ready) is_read_r <= in_op;
      if (state_r == ST_OUT && !is_read_r) begin
        ready_r <= 1'b1; gen_len_r <= len_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    twi_r <= twi_nxt; prev_r <= prev_nxt; wa_r <= wa_nxt; m_r <= m_nxt;
    fidx_r <= fidx_nxt; rem_r <= rem_nxt; quo_r <= quo_nxt; bit_r <= bit_nxt;
    tval_r <= tval_nxt; ridx_r <= ridx_nxt; oerr_r <= oerr_nxt;
    oval_r <= (state_r == ST_OUT && is_read_r) ? pt_rdata : oval_nxt;
  end
endmodule

[hdl/kpg_ram.sv]
// Generic single-port synchronous RAM with a registered read.
`timescale 1ns / 1ps
module kpg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[hdl/kpg_checker.sv]
// Port-level checker for the keyed permutation generator, bound to the top level.
`timescale 1ns / 1ps
module kpg_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [11:0] out_perm_value,
  input logic out_error_flag
);
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_flag |-> out_perm_value == 12'd0)
    else $error("error result with nonzero value");
  a_no_accept_while_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result waits");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_perm_value))
    else $error("result dropped while stalled");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken next cycle");
endmodule

bind keyed_permutation_generator kpg_checker u_kpg_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_perm_value(out_perm_value), .out_error_flag(out_error_flag));
